### design/ura_pkg.sv
package ura_pkg;

  // Radix modes
  localparam logic [1:0] MODE_DEC  = 2'd0;
  localparam logic [1:0] MODE_OCT  = 2'd1;
  localparam logic [1:0] MODE_HEXL = 2'd2;
  localparam logic [1:0] MODE_HEXU = 2'd3;

  // Size modes (code 3 falls back to 32 bits)
  localparam logic [1:0] SIZE_32 = 2'd0;
  localparam logic [1:0] SIZE_64 = 2'd1;
  localparam logic [1:0] SIZE_16 = 2'd2;

  // ASCII codes
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_LOWER_X = 7'h78;
  localparam logic [6:0] CH_UPPER_X = 7'h58;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_UPPER_A = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CONV,
    ST_PFX0,
    ST_PFXX,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_X,
    EMIT_DIGIT
  } emit_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_OCT,
    PFX_HEX
  } pfx_t;

  typedef struct packed {
    logic  load;
    logic  conv;
    logic  shift;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    pfx_t pfx;
    logic conv_last;
    logic top_zero;
    logic one_left;
  } status_t;

  // Map one digit value to its ASCII character
  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b000, d};
    end else if (upper) begin
      c = CH_UPPER_A + {3'b000, d} - 7'd10;
    end else begin
      c = CH_LOWER_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

### design/unsigned_to_radix_ascii.sv
// Unsigned integer to ASCII text in decimal, octal or hex.
//
// Input: raise start with value, mode, size_mode and alt_form; the item is
// taken at the clock edge where start is high and busy is low. busy stays
// high until the final character has been issued.
// Output: one character per strobe cycle on char_code, with last set on the
// final character. Characters are issued without back-pressure; the
// receiver must take each one in the cycle it appears.
// Sequence: a setup step after the start transfer, then
//   decimal: bit-serial shift-and-add-3 conversion of the VALUE_BITS input
//            bits, then the BCD digit slots in turn (leading zeros dropped);
//   octal:   optional 0 prefix, then the octal digit slots in turn;
//   hex:     optional 0x or 0X prefix, then the hex digit slots in turn.
// A new item can be started in the cycle the last character is on the port.
// Reset (rst, synchronous) returns the controller to idle and drops strobe.
module unsigned_to_radix_ascii #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [1:0]            mode,
  input  logic [1:0]            size_mode,
  input  logic                  alt_form,
  output logic [6:0]            char_code,
  output logic                  last,
  output logic                  strobe
);
  import ura_pkg::*;

  cmd_t    cmd;
  status_t status;

  ura_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ura_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .mode      (mode),
    .size_mode (size_mode),
    .alt_form  (alt_form),
    .status    (status),
    .char_code (char_code),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

### design/ura_ctrl.sv
module ura_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ura_pkg::status_t status,
  output ura_pkg::cmd_t    cmd,
  output logic             busy
);
  import ura_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.conv   = 1'b0;
    cmd.shift  = 1'b0;
    cmd.emit   = EMIT_NONE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status.is_dec) begin
          state_next = ST_CONV;
        end else if (status.pfx != PFX_NONE) begin
          state_next = ST_PFX0;
        end else begin
          state_next = ST_SKIP;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_PFX0: begin
        cmd.emit   = EMIT_ZERO;
        state_next = (status.pfx == PFX_HEX) ? ST_PFXX : ST_SKIP;
      end
      ST_PFXX: begin
        cmd.emit   = EMIT_X;
        state_next = ST_SKIP;
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        cmd.shift = 1'b1;
        if (!(status.top_zero && !status.one_left)) begin
          cmd.emit   = EMIT_DIGIT;
          state_next = status.one_left ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.shift = 1'b1;
        cmd.emit  = EMIT_DIGIT;
        if (status.one_left) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### design/ura_datapath.sv
module ura_datapath #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ura_pkg::cmd_t         cmd,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [1:0]            mode,
  input  logic [1:0]            size_mode,
  input  logic                  alt_form,
  output ura_pkg::status_t      status,
  output logic [6:0]            char_code,
  output logic                  last,
  output logic                  strobe
);
  import ura_pkg::*;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int MAX_DIGITS = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
  localparam int SR_W       = 4 * DEC_DIGITS;
  localparam int OCT_SHIFT  = SR_W - 3 * OCT_DIGITS;
  localparam int HEX_SHIFT  = SR_W - 4 * HEX_DIGITS;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W      = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] num;
  logic [VALUE_BITS-1:0] narrowed;
  logic [VALUE_BITS-1:0] mask;
  logic [SR_W-1:0]       sr;
  logic [SR_W-1:0]       sr_adj;
  logic [SR_W-1:0]       value_ext;
  logic [CNT_W-1:0]      cnt;
  logic [BIT_W-1:0]      bits;
  logic [1:0]            mode_q;
  pfx_t                  pfx;
  pfx_t                  pfx_in;
  logic                  is_oct;
  logic [3:0]            digit;

  // Narrow the incoming value
  always_comb begin
    unique case (size_mode)
      SIZE_64: mask = '1;
      SIZE_16: mask = VALUE_BITS'(17'h0FFFF);
      default: mask = VALUE_BITS'(33'h0FFFFFFFF);
    endcase
    narrowed  = value & mask;
    value_ext = {{(SR_W - VALUE_BITS){1'b0}}, narrowed};
  end

  // Decide the prefix from the value before narrowing
  always_comb begin
    pfx_in = PFX_NONE;
    if (alt_form && (value != '0)) begin
      unique case (mode) inside
        MODE_OCT:             pfx_in = PFX_OCT;
        MODE_HEXL, MODE_HEXU: pfx_in = PFX_HEX;
        default:              pfx_in = PFX_NONE;
      endcase
    end
  end

  // Add 3 to every BCD digit of five or more
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (sr[4*i +: 4] >= 4'd5) begin
        sr_adj[4*i +: 4] = sr[4*i +: 4] + 4'd3;
      end else begin
        sr_adj[4*i +: 4] = sr[4*i +: 4];
      end
    end
  end

  assign is_oct = (mode_q == MODE_OCT);
  assign digit  = is_oct ? {1'b0, sr[SR_W-1 -: 3]} : sr[SR_W-1 -: 4];

  // Load, convert one bit, or advance one digit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num    <= narrowed;
      mode_q <= mode;
      pfx    <= pfx_in;
      bits   <= BIT_W'(VALUE_BITS);
      unique case (mode)
        MODE_DEC: begin
          sr  <= '0;
          cnt <= CNT_W'(DEC_DIGITS);
        end
        MODE_OCT: begin
          sr  <= value_ext << OCT_SHIFT;
          cnt <= CNT_W'(OCT_DIGITS);
        end
        default: begin
          sr  <= value_ext << HEX_SHIFT;
          cnt <= CNT_W'(HEX_DIGITS);
        end
      endcase
    end else if (cmd.conv) begin
      sr   <= {sr_adj[SR_W-2:0], num[VALUE_BITS-1]};
      num  <= {num[VALUE_BITS-2:0], 1'b0};
      bits <= bits - 1'b1;
    end else if (cmd.shift) begin
      sr  <= is_oct ? (sr << 3) : (sr << 4);
      cnt <= cnt - 1'b1;
    end
  end

  assign status.is_dec    = (mode_q == MODE_DEC);
  assign status.pfx       = pfx;
  assign status.conv_last = (bits == BIT_W'(1));
  assign status.top_zero  = (digit == 4'd0);
  assign status.one_left  = (cnt == CNT_W'(1));

  // Strobe for one cycle per character transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != EMIT_NONE);
    end
  end

  // Hold the character until the next one
  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_ZERO: begin
        char_code <= CH_ZERO;
        last      <= 1'b0;
      end
      EMIT_X: begin
        char_code <= (mode_q == MODE_HEXU) ? CH_UPPER_X : CH_LOWER_X;
        last      <= 1'b0;
      end
      EMIT_DIGIT: begin
        char_code <= digit_char(digit, mode_q == MODE_HEXU);
        last      <= status.one_left;
      end
      default: begin
        char_code <= char_code;
        last      <= last;
      end
    endcase
  end

endmodule

### design/ura_checker.sv
module ura_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last
);

  // No character transfer right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  // An accepted start makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  // More characters follow while busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final character while idle");

  // Final character ends the item
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("busy on final character");

  // Nothing follows the final character in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("character right after final character");

endmodule

bind unsigned_to_radix_ascii ura_checker u_chk (.*);

### tb/unsigned_to_radix_ascii_test.sv
`timescale 1ns / 100ps

module unsigned_to_radix_ascii_test;
  import ura_pkg::*;

  // Unused size code: narrows like the 32-bit mode
  localparam logic [1:0] SIZE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 320;

  typedef struct {
    logic [6:0] code;
    logic       fin;
  } text_char_t;

  // Predict the characters of each number and match them against the block
  class ascii_tracker;
    text_char_t pending_chars[$];
    int         mismatch_count = 0;

    function int pending();
      return pending_chars.size();
    endfunction

    // Render one accepted number into its expected characters
    function void note_number(logic [63:0] v, logic [1:0] md, logic [1:0] sz, logic alt);
      logic [63:0] num;
      logic [63:0] base;
      string       glyphs;
      logic [6:0]  text_q[$];
      text_char_t  item;

      if (sz == SIZE_64) begin
        num = v;
      end else if (sz == SIZE_16) begin
        num = {48'd0, v[15:0]};
      end else begin
        num = {32'd0, v[31:0]};
      end
      base = (md == MODE_DEC) ? 64'd10 : (md == MODE_OCT) ? 64'd8 : 64'd16;
      glyphs = (md == MODE_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";

      // Peel digits off the low end, building the text right to left
      if (num == 64'd0) text_q.push_front(CH_ZERO);
      while (num != 64'd0) begin
        text_q.push_front(7'(glyphs[int'(num % base)]));
        num = num / base;
      end

      // Prefix depends on the value before narrowing
      if (alt && v != 64'd0) begin
        if (md == MODE_OCT) begin
          text_q.push_front(CH_ZERO);
        end else if (md == MODE_HEXL || md == MODE_HEXU) begin
          text_q.push_front((md == MODE_HEXU) ? CH_UPPER_X : CH_LOWER_X);
          text_q.push_front(CH_ZERO);
        end
      end

      foreach (text_q[k]) begin
        item.code = text_q[k];
        item.fin  = (k == text_q.size() - 1);
        pending_chars.push_back(item);
      end
    endfunction

    // Compare one character transfer with the oldest expectation
    function void check_char(logic [6:0] code, logic fin);
      text_char_t want;

      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected char: char_code=%h last=%b", code, fin);
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code || fin !== want.fin) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("char mismatch: expected char_code=%h last=%b, got char_code=%h last=%b",
                   want.code, want.fin, code, fin);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] value;
  logic [1:0]  mode;
  logic [1:0]  size_mode;
  logic        alt_form;
  logic [6:0]  char_code;
  logic        last;
  logic        strobe;

  ascii_tracker ledger = new();
  int           quiet_cycles = 0;

  unsigned_to_radix_ascii #(.VALUE_BITS(64)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .mode      (mode),
    .size_mode (size_mode),
    .alt_form  (alt_form),
    .char_code (char_code),
    .last      (last),
    .strobe    (strobe)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Observe transfers on both sides and watch for a stalled run
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) ledger.note_number(value, mode, size_mode, alt_form);
      if (strobe) ledger.check_char(char_code, last);
      if ((start && !busy) || strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[unsigned_to_radix_ascii] ERROR");
        $finish;
      end
    end
  end

  // Present one number and hold it until the block takes it
  task automatic issue_number(logic [63:0] v, logic [1:0] md, logic [1:0] sz, logic alt);
    @(negedge clk);
    start     <= 1'b1;
    value     <= v;
    mode      <= md;
    size_mode <= sz;
    alt_form  <= alt;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold it low for the requested span
  task automatic hold_off(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop start and wait for every predicted character
  task automatic drain_text();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] v;
    int          shape;
    int          span;

    rst       = 1'b1;
    start     = 1'b0;
    value     = 64'd0;
    mode      = MODE_DEC;
    size_mode = SIZE_32;
    alt_form  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero, extremes, every radix and size, prefix corner cases
    issue_number(64'd0, MODE_DEC, SIZE_32, 1'b0);
    issue_number(64'd0, MODE_OCT, SIZE_64, 1'b1);
    issue_number(64'd0, MODE_HEXL, SIZE_16, 1'b1);
    issue_number('1, MODE_DEC, SIZE_64, 1'b0);
    issue_number('1, MODE_OCT, SIZE_64, 1'b1);
    issue_number('1, MODE_HEXL, SIZE_64, 1'b1);
    issue_number('1, MODE_HEXU, SIZE_64, 1'b1);
    issue_number('1, MODE_HEXU, SIZE_16, 1'b0);
    issue_number('1, MODE_DEC, SIZE_32, 1'b1);
    issue_number('1, MODE_HEXL, SIZE_SPARE, 1'b1);
    issue_number('1, MODE_DEC, SIZE_SPARE, 1'b0);
    issue_number(64'h0000_0001_0000_0000, MODE_OCT, SIZE_32, 1'b1);
    issue_number(64'h0000_0000_0001_0000, MODE_HEXL, SIZE_16, 1'b1);
    issue_number(64'h0000_0000_0001_0000, MODE_HEXU, SIZE_16, 1'b1);
    issue_number(64'hABCD_0000_0000_0000, MODE_HEXU, SIZE_SPARE, 1'b1);
    issue_number(64'd12345, MODE_DEC, SIZE_32, 1'b1);
    issue_number(64'h8000_0000_0000_0000, MODE_DEC, SIZE_64, 1'b0);
    issue_number(64'hDEAD_BEEF_CAFE_F00D, MODE_HEXL, SIZE_64, 1'b1);
    issue_number(64'hDEAD_BEEF_CAFE_F00D, MODE_HEXU, SIZE_64, 1'b0);
    issue_number(64'd1, MODE_OCT, SIZE_16, 1'b1);
    issue_number(64'd9, MODE_DEC, SIZE_16, 1'b0);
    issue_number(64'd10, MODE_DEC, SIZE_16, 1'b0);
    issue_number(64'd8, MODE_OCT, SIZE_32, 1'b0);
    issue_number(64'hFFFF_FFFF_0000_FFFF, MODE_DEC, SIZE_64, 1'b0);
    drain_text();

    // Random numbers in mixed shapes; no idling in the middle stretch
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      shape = $urandom_range(3);
      v = {$urandom, $urandom};
      case (shape)
        0: begin
        end
        1: begin
          v = 64'($urandom_range(40));
        end
        2: begin
          span = $urandom_range(1, 64);
          v = (span == 64) ? v : (v & ((64'd1 << span) - 64'd1));
        end
        default: begin
          v = $urandom_range(1) ? {v[63:32], 32'd0} : {v[63:16], 16'd0};
        end
      endcase
      issue_number(v, 2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      if (i == 60 || i == 250) drain_text();
      if ((i < 120 || i >= 200) && $urandom_range(99) < 21) hold_off($urandom_range(1, 12));
    end

    // Let the last characters arrive, then watch for strays
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (ledger.mismatch_count == 0 && ledger.pending() == 0) begin
      $display("[unsigned_to_radix_ascii] OK");
    end else begin
      $display("[unsigned_to_radix_ascii] ERROR");
    end
    $finish;
  end

endmodule
